// File: sv/nrmc_pkg.sv
`default_nettype none

package nrmc_pkg;

    // Number of decimal fraction digits kept in the fixed-point fields.
    localparam int FRAC_DIGITS = 5;

    localparam int BYTE_W   = 8;
    localparam int ACC_W    = 36;
    localparam int POW_W    = 20;
    localparam int PROD_W   = ACC_W + POW_W;
    localparam int TIME_W   = 35;
    localparam int HLAT_W   = 30;
    localparam int HLON_W   = 31;
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int SPEED_W  = 34;
    localparam int COURSE_W = 26;
    localparam int DATE_W   = 19;
    localparam int FRAC_W   = 3;
    localparam int FIELD_W  = 4;

    localparam logic [ACC_W-1:0]    ACC_MAX    = 36'hF_FFFF_FFFF;
    localparam logic [TIME_W-1:0]   TIME_MAX   = 35'd23596099999;
    localparam logic [TIME_W-1:0]   LAT_MAX    = 35'd900000000;
    localparam logic [TIME_W-1:0]   LON_MAX    = 35'd1800000000;
    localparam logic [TIME_W-1:0]   SPEED_MAX  = 35'd9999999999;
    localparam logic [TIME_W-1:0]   COURSE_MAX = 35'd36000000;
    localparam logic [DATE_W-1:0]   DATE_MAX   = 19'd311299;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A_UP   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F_UP   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_A_LOW  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F_LOW  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_S_UP   = 8'h53;
    localparam logic [BYTE_W-1:0] CH_W_UP   = 8'h57;
    localparam logic [3:0]        NIBBLE_MASK = 4'hF;

    localparam int ID_LEN = 5;

    // Comma-separated field positions within an RMC sentence.
    localparam logic [FIELD_W-1:0] FLD_ID     = 4'd0;
    localparam logic [FIELD_W-1:0] FLD_TIME   = 4'd1;
    localparam logic [FIELD_W-1:0] FLD_FIX    = 4'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT    = 4'd3;
    localparam logic [FIELD_W-1:0] FLD_NS     = 4'd4;
    localparam logic [FIELD_W-1:0] FLD_LON    = 4'd5;
    localparam logic [FIELD_W-1:0] FLD_EW     = 4'd6;
    localparam logic [FIELD_W-1:0] FLD_SPEED  = 4'd7;
    localparam logic [FIELD_W-1:0] FLD_COURSE = 4'd8;
    localparam logic [FIELD_W-1:0] FLD_DATE   = 4'd9;
    localparam logic [FIELD_W-1:0] FLD_LAST   = 4'd15;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_BAD_ID   = 2'd2
    } t_status;

    // First member sits in the highest bits, so the status lands in bits 1:0.
    typedef struct packed {
        logic [DATE_W-1:0]   date_value;
        logic [COURSE_W-1:0] course;
        logic [SPEED_W-1:0]  speed;
        logic [LON_W-1:0]    longitude;
        logic [LAT_W-1:0]    latitude;
        logic [TIME_W-1:0]   fix_time;
        logic                fix_valid;
        t_status             status;
    } t_result;

    localparam int RES_W   = $bits(t_result);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] e);
        logic [POW_W-1:0] v;
        unique case (e)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            3'd6:    v = 20'd1000000;
            default: v = 20'd1;
        endcase
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] id_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] v;
        unique case (pos)
            3'd0:    v = 8'h47;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h52;
            3'd3:    v = 8'h4D;
            3'd4:    v = 8'h43;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/nrmc_in_stage.sv
`default_nettype none

module nrmc_in_stage
    import nrmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data,
    input  wire logic              i_take,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_data
);

    logic              r_vld;
    logic [BYTE_W-1:0] r_data;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/nrmc_core.sv
`default_nettype none

module nrmc_core
    import nrmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_emit,
    output t_result                o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_HEX1,
        PH_HEX2
    } t_phase;

    t_phase               r_phase,   n_phase;
    logic [BYTE_W-1:0]    r_xor,     n_xor;
    logic [3:0]           r_first,   n_first;
    logic [2:0]           r_id_pos,  n_id_pos;
    logic                 r_id_ok,   n_id_ok;
    logic [FIELD_W-1:0]   r_field,   n_field;
    logic [ACC_W-1:0]     r_acc,     n_acc;
    logic [FRAC_W-1:0]    r_frac,    n_frac;
    logic                 r_seen,    n_seen;
    logic                 r_ended,   n_ended;
    logic                 r_fix,     n_fix;
    logic                 r_south,   n_south;
    logic                 r_west,    n_west;
    logic [TIME_W-1:0]    r_time,    n_time;
    logic [HLAT_W-1:0]    r_lat,     n_lat;
    logic [HLON_W-1:0]    r_lon,     n_lon;
    logic [SPEED_W-1:0]   r_speed,   n_speed;
    logic [COURSE_W-1:0]  r_course,  n_course;
    logic [DATE_W-1:0]    r_date,    n_date;

    logic                 w_is_digit;
    logic                 w_is_hex_letter;
    logic [3:0]           w_hex;
    logic [ACC_W+3:0]     w_acc_mul;
    logic [ACC_W-1:0]     w_acc_next;
    logic [FRAC_W-1:0]    w_shift;
    logic [PROD_W-1:0]    w_prod;
    logic [TIME_W-1:0]    w_cap;
    logic [TIME_W-1:0]    w_scaled;
    logic [DATE_W-1:0]    w_date_cap;
    logic                 w_int_only;
    logic                 w_num_field;
    logic                 w_skip_digit;
    t_status              w_status;

    assign w_is_digit      = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_is_hex_letter = ((i_byte >= CH_A_UP) && (i_byte <= CH_F_UP))
                          || ((i_byte >= CH_A_LOW) && (i_byte <= CH_F_LOW));
    // Letters A-F/a-f have low nibbles 1-6; other bytes keep (byte - '0') & 0xF.
    assign w_hex = w_is_hex_letter ? (i_byte[3:0] + 4'd9) : (i_byte[3:0] & NIBBLE_MASK);

    // Decimal accumulation: acc * 10 + digit, saturating at the accumulator range.
    assign w_acc_mul  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {36'd0, (i_byte[3:0] & NIBBLE_MASK)};
    assign w_acc_next = (w_acc_mul > {4'd0, ACC_MAX}) ? ACC_MAX : w_acc_mul[ACC_W-1:0];

    // Scale the closing field up to the full fraction width and clamp it.
    assign w_shift  = FRAC_W'(FRAC_DIGITS) - r_frac;
    assign w_prod   = r_acc * pow10(w_shift);
    assign w_date_cap = (r_acc > {17'd0, DATE_MAX}) ? DATE_MAX : r_acc[DATE_W-1:0];

    always_comb begin
        unique case (r_field)
            FLD_TIME:   w_cap = TIME_MAX;
            FLD_LAT:    w_cap = LAT_MAX;
            FLD_LON:    w_cap = LON_MAX;
            FLD_SPEED:  w_cap = SPEED_MAX;
            default:    w_cap = COURSE_MAX;
        endcase
    end

    assign w_scaled = (w_prod > {21'd0, w_cap}) ? w_cap : w_prod[TIME_W-1:0];

    assign w_int_only  = (r_field == FLD_DATE);
    assign w_num_field = (r_field == FLD_TIME) || (r_field == FLD_LAT)
                      || (r_field == FLD_LON) || (r_field == FLD_SPEED)
                      || (r_field == FLD_COURSE) || w_int_only;
    assign w_skip_digit = r_seen && !w_int_only && (r_frac >= FRAC_W'(FRAC_DIGITS));

    always_comb begin
        if (r_xor != {r_first, w_hex}) begin
            w_status = ST_CSUM_ERR;
        end else if (!r_id_ok || (r_id_pos < 3'(ID_LEN))) begin
            w_status = ST_BAD_ID;
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_emit = (r_phase == PH_HEX2) && (i_byte != CH_DOLLAR);

    always_comb begin
        o_res = '0;
        o_res.status = w_status;
        if (w_status == ST_OK) begin
            o_res.fix_valid  = r_fix;
            o_res.fix_time   = r_time;
            o_res.latitude   = r_south ? (LAT_W'(0) - {1'b0, r_lat}) : {1'b0, r_lat};
            o_res.longitude  = r_west ? (LON_W'(0) - {1'b0, r_lon}) : {1'b0, r_lon};
            o_res.speed      = r_speed;
            o_res.course     = r_course;
            o_res.date_value = r_date;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_first  = r_first;
        n_id_pos = r_id_pos;
        n_id_ok  = r_id_ok;
        n_field  = r_field;
        n_acc    = r_acc;
        n_frac   = r_frac;
        n_seen   = r_seen;
        n_ended  = r_ended;
        n_fix    = r_fix;
        n_south  = r_south;
        n_west   = r_west;
        n_time   = r_time;
        n_lat    = r_lat;
        n_lon    = r_lon;
        n_speed  = r_speed;
        n_course = r_course;
        n_date   = r_date;

        if (i_byte == CH_DOLLAR) begin
            n_phase  = PH_BODY;
            n_xor    = '0;
            n_first  = '0;
            n_id_pos = '0;
            n_id_ok  = 1'b1;
            n_field  = FLD_ID;
            n_acc    = '0;
            n_frac   = '0;
            n_seen   = 1'b0;
            n_ended  = 1'b0;
            n_fix    = 1'b0;
            n_south  = 1'b0;
            n_west   = 1'b0;
            n_time   = '0;
            n_lat    = '0;
            n_lon    = '0;
            n_speed  = '0;
            n_course = '0;
            n_date   = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_BODY: begin
                    if (i_byte != CH_STAR) begin
                        n_xor = r_xor ^ i_byte;
                    end
                    if ((i_byte == CH_STAR) || (i_byte == CH_COMMA)) begin
                        // Field close: latch the decoded value, reset the number parser.
                        unique case (r_field)
                            FLD_TIME:   n_time   = w_scaled;
                            FLD_LAT:    n_lat    = w_scaled[HLAT_W-1:0];
                            FLD_LON:    n_lon    = w_scaled[HLON_W-1:0];
                            FLD_SPEED:  n_speed  = w_scaled[SPEED_W-1:0];
                            FLD_COURSE: n_course = w_scaled[COURSE_W-1:0];
                            FLD_DATE:   n_date   = w_date_cap;
                            default: begin
                            end
                        endcase
                        n_acc   = '0;
                        n_frac  = '0;
                        n_seen  = 1'b0;
                        n_ended = 1'b0;
                        if (i_byte == CH_STAR) begin
                            n_phase = PH_HEX1;
                        end else if (r_field != FLD_LAST) begin
                            n_field = r_field + 4'd1;
                        end
                    end else if (r_field == FLD_ID) begin
                        if (r_id_pos < 3'(ID_LEN)) begin
                            if (i_byte != id_char(r_id_pos)) begin
                                n_id_ok = 1'b0;
                            end
                            n_id_pos = r_id_pos + 3'd1;
                        end
                    end else if (w_num_field) begin
                        if (!r_ended) begin
                            if (w_is_digit) begin
                                if (!w_skip_digit) begin
                                    if (r_seen && !w_int_only) begin
                                        n_frac = r_frac + 3'd1;
                                    end
                                    n_acc = w_acc_next;
                                end
                            end else if ((i_byte == CH_POINT) && !r_seen && !w_int_only) begin
                                n_seen = 1'b1;
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end else if ((r_field == FLD_FIX) || (r_field == FLD_NS)
                              || (r_field == FLD_EW)) begin
                        // Only the first character of a letter field counts.
                        if (!r_seen) begin
                            if ((r_field == FLD_FIX) && (i_byte == CH_A_UP)) n_fix = 1'b1;
                            if ((r_field == FLD_NS) && (i_byte == CH_S_UP)) n_south = 1'b1;
                            if ((r_field == FLD_EW) && (i_byte == CH_W_UP)) n_west = 1'b1;
                            n_seen = 1'b1;
                        end
                    end
                end
                PH_HEX1: begin
                    n_first = w_hex;
                    n_phase = PH_HEX2;
                end
                PH_HEX2: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_xor    <= '0;
            r_first  <= '0;
            r_id_pos <= '0;
            r_id_ok  <= 1'b1;
            r_field  <= FLD_ID;
            r_acc    <= '0;
            r_frac   <= '0;
            r_seen   <= 1'b0;
            r_ended  <= 1'b0;
            r_fix    <= 1'b0;
            r_south  <= 1'b0;
            r_west   <= 1'b0;
            r_time   <= '0;
            r_lat    <= '0;
            r_lon    <= '0;
            r_speed  <= '0;
            r_course <= '0;
            r_date   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_first  <= n_first;
            r_id_pos <= n_id_pos;
            r_id_ok  <= n_id_ok;
            r_field  <= n_field;
            r_acc    <= n_acc;
            r_frac   <= n_frac;
            r_seen   <= n_seen;
            r_ended  <= n_ended;
            r_fix    <= n_fix;
            r_south  <= n_south;
            r_west   <= n_west;
            r_time   <= n_time;
            r_lat    <= n_lat;
            r_lon    <= n_lon;
            r_speed  <= n_speed;
            r_course <= n_course;
            r_date   <= n_date;
        end
    end

    a_emit_ends_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit) |=> (r_phase == PH_IDLE))
        else $error("sentence did not return to idle after its result");

    a_dollar_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_byte == CH_DOLLAR)) |=> ((r_phase == PH_BODY) && (r_xor == '0)
                                               && (r_field == FLD_ID)))
        else $error("start character did not restart the sentence");

    a_fraction_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= FRAC_W'(FRAC_DIGITS))
        else $error("fraction digit count ran past its limit");

endmodule

`default_nettype wire

// File: sv/nrmc_out_stage.sv
`default_nettype none

module nrmc_out_stage
    import nrmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  t_result      i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_vld;
    t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_vld || i_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: sv/nmea_rmc_sentence_parser.sv
`default_nettype none

// NMEA-0183 RMC sentence parser.
//
// The slave stream carries one ASCII character per transaction in
// s_axis_tdata. A '$' opens a sentence; the body is checksummed and split
// into comma fields, and the two hex digits after '*' close it. On the
// second checksum digit one result transaction goes out on the master
// stream: status, fix flag, time, signed latitude and longitude, speed and
// course (fixed point, scaled by 10^FRAC_DIGITS) and the date. Characters
// outside a sentence produce nothing.
//
// Each character is registered in the input stage, decoded combinationally
// and, if it closes a sentence, written to the result register, so a result
// reaches the master stream through the input register and then the result
// register. One character is taken every cycle; the only thing that can hold
// the input is a closing checksum digit that finds the result register still
// occupied by an untaken result.
// When the receiver stalls, the result holds and the input keeps flowing
// until such a digit arrives. Reset (synchronous, active low) empties both
// registers and returns the parser to waiting for '$'.

module nmea_rmc_sentence_parser
    import nrmc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_in

    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // From bit 0: status[1:0], fix_valid[2], fix_time[37:3],
    // latitude[68:38], longitude[100:69], speed[134:101], course[160:135],
    // date_value[179:161], zero fill[183:180].
    output logic [TDATA_W-1:0]      m_axis_tdata
);

    logic              w_in_vld;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_emit;
    logic              w_out_free;
    logic              w_step;
    t_result           w_res;
    t_result           w_out_res;

    // A registered character advances unless it would produce a result
    // while the result register cannot accept it.
    assign w_step = w_in_vld && (!w_emit || w_out_free);

    nrmc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (w_step),
        .o_valid (w_in_vld),
        .o_data  (w_in_byte)
    );

    nrmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (w_in_byte),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    nrmc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_emit),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = {(TDATA_W - RES_W)'(0), w_out_res};

endmodule

`default_nettype wire

// File: tb/sv/rmc_report_checker.sv
`timescale 1ns / 1ps

module rmc_report_checker
    import nrmc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_char_valid,
    input  wire logic               i_char_ready,
    input  wire logic [BYTE_W-1:0]  i_char,
    input  wire logic               i_report_valid,
    input  wire logic               i_report_ready,
    input  wire logic [TDATA_W-1:0] i_report,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_SUM_HI,
        PH_SUM_LO
    } t_phase;

    localparam logic [8*ID_LEN-1:0] RMC_ID = "GPRMC";

    t_phase              phase;
    logic [7:0]          xor_run;
    logic [3:0]          hi_nibble;
    logic [2:0]          id_count;
    logic                id_ok;
    logic [FIELD_W-1:0]  field_idx;
    logic [ACC_W-1:0]    digit_acc;
    logic [FRAC_W-1:0]   frac_count;
    logic                point_seen;
    logic                num_done;
    logic                fix_seen;
    logic                south_seen;
    logic                west_seen;
    logic [TIME_W-1:0]   time_val;
    logic [HLAT_W-1:0]   lat_val;
    logic [HLON_W-1:0]   lon_val;
    logic [SPEED_W-1:0]  speed_val;
    logic [COURSE_W-1:0] course_val;
    logic [DATE_W-1:0]   date_val;

    t_result reports_due[$];
    int      mismatch_total = 0;
    int      received = 0;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_A_UP && c <= CH_F_UP) begin
            v = c - CH_A_UP + 8'd10;
        end else if (c >= CH_A_LOW && c <= CH_F_LOW) begin
            v = c - CH_A_LOW + 8'd10;
        end else begin
            v = c - CH_ZERO;
        end
        return v[3:0];
    endfunction

    function automatic void start_sentence();
        xor_run    = '0;
        hi_nibble  = '0;
        id_count   = '0;
        id_ok      = 1'b1;
        field_idx  = FLD_ID;
        digit_acc  = '0;
        frac_count = '0;
        point_seen = 1'b0;
        num_done   = 1'b0;
        fix_seen   = 1'b0;
        south_seen = 1'b0;
        west_seen  = 1'b0;
        time_val   = '0;
        lat_val    = '0;
        lon_val    = '0;
        speed_val  = '0;
        course_val = '0;
        date_val   = '0;
    endfunction

    // Pads the number out to FRAC_DIGITS fraction digits, then clamps it.
    function automatic logic [63:0] scaled(input logic [63:0] cap);
        logic [63:0] v;
        int          shift;
        v = {28'd0, digit_acc};
        shift = FRAC_DIGITS - int'(frac_count);
        if (shift < 0) shift = 0;
        for (int i = 0; i < shift; i++) v = v * 64'd10;
        return (v > cap) ? cap : v;
    endfunction

    function automatic void close_field();
        logic [63:0] v;
        case (field_idx)
            FLD_TIME: begin
                v = scaled(64'(TIME_MAX));
                time_val = v[TIME_W-1:0];
            end
            FLD_LAT: begin
                v = scaled(64'(LAT_MAX));
                lat_val = v[HLAT_W-1:0];
            end
            FLD_LON: begin
                v = scaled(64'(LON_MAX));
                lon_val = v[HLON_W-1:0];
            end
            FLD_SPEED: begin
                v = scaled(64'(SPEED_MAX));
                speed_val = v[SPEED_W-1:0];
            end
            FLD_COURSE: begin
                v = scaled(64'(COURSE_MAX));
                course_val = v[COURSE_W-1:0];
            end
            FLD_DATE: begin
                date_val = (digit_acc > 36'(DATE_MAX)) ? DATE_MAX : digit_acc[DATE_W-1:0];
            end
            default: ;
        endcase
        digit_acc  = '0;
        frac_count = '0;
        point_seen = 1'b0;
        num_done   = 1'b0;
    endfunction

    function automatic void take_number_char(input logic [7:0] c, input logic int_only);
        logic [63:0] grown;
        if (num_done) return;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (point_seen && !int_only) begin
                if (int'(frac_count) >= FRAC_DIGITS) return;
                frac_count++;
            end
            grown = {28'd0, digit_acc} * 64'd10 + {56'd0, c - CH_ZERO};
            digit_acc = (grown > {28'd0, ACC_MAX}) ? ACC_MAX : grown[ACC_W-1:0];
        end else if (c == CH_POINT && !point_seen && !int_only) begin
            point_seen = 1'b1;
        end else begin
            num_done = 1'b1;
        end
    endfunction

    function automatic void body_char(input logic [7:0] c);
        if (c == CH_COMMA) begin
            close_field();
            if (field_idx < FLD_LAST) field_idx++;
            return;
        end
        case (field_idx)
            FLD_ID: begin
                if (id_count < ID_LEN) begin
                    if (c != RMC_ID[8*(ID_LEN-1-int'(id_count)) +: 8]) id_ok = 1'b0;
                    id_count++;
                end
            end
            FLD_TIME, FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: take_number_char(c, 1'b0);
            FLD_DATE: take_number_char(c, 1'b1);
            FLD_FIX, FLD_NS, FLD_EW: begin
                // Letter fields: the point flag doubles as "first character seen".
                if (!point_seen) begin
                    if (field_idx == FLD_FIX && c == CH_A_UP) fix_seen = 1'b1;
                    if (field_idx == FLD_NS && c == CH_S_UP) south_seen = 1'b1;
                    if (field_idx == FLD_EW && c == CH_W_UP) west_seen = 1'b1;
                    point_seen = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_char(input logic [7:0] c, output logic made,
                                       output t_result rep);
        made = 1'b0;
        rep  = '0;
        if (c == CH_DOLLAR) begin
            start_sentence();
            phase = PH_BODY;
            return;
        end
        case (phase)
            PH_HUNT: ;
            PH_BODY: begin
                if (c == CH_STAR) begin
                    close_field();
                    phase = PH_SUM_HI;
                end else begin
                    xor_run = xor_run ^ c;
                    body_char(c);
                end
            end
            PH_SUM_HI: begin
                hi_nibble = hex_nibble(c);
                phase = PH_SUM_LO;
            end
            default: begin
                phase = PH_HUNT;
                made = 1'b1;
                if (xor_run != {hi_nibble, hex_nibble(c)}) begin
                    rep.status = ST_CSUM_ERR;
                end else if (!id_ok || id_count < ID_LEN) begin
                    rep.status = ST_BAD_ID;
                end else begin
                    rep.status     = ST_OK;
                    rep.fix_valid  = fix_seen;
                    rep.fix_time   = time_val;
                    rep.latitude   = south_seen ? -{1'b0, lat_val} : {1'b0, lat_val};
                    rep.longitude  = west_seen ? -{1'b0, lon_val} : {1'b0, lon_val};
                    rep.speed      = speed_val;
                    rep.course     = course_val;
                    rep.date_value = date_val;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("report %0d: %s is 0x%0h, expected 0x%0h", received, what, got, want);
        mismatch_total++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        logic    made;
        t_result due;
        t_result seen;
        if (!i_rst_n) begin
            phase = PH_HUNT;
            start_sentence();
            reports_due.delete();
        end else begin
            if (i_char_valid && i_char_ready) begin
                parse_char(i_char, made, due);
                if (made) reports_due.push_back(due);
            end
            if (i_report_valid && i_report_ready) begin
                seen = i_report[RES_W-1:0];
                received++;
                if (reports_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 64'(seen.status), 64'd0);
                end else begin
                    due = reports_due.pop_front();
                    check_field("status", 64'(seen.status), 64'(due.status));
                    check_field("fix_valid", 64'(seen.fix_valid), 64'(due.fix_valid));
                    check_field("fix_time", 64'(seen.fix_time), 64'(due.fix_time));
                    check_field("latitude", 64'(seen.latitude), 64'(due.latitude));
                    check_field("longitude", 64'(seen.longitude), 64'(due.longitude));
                    check_field("speed", 64'(seen.speed), 64'(due.speed));
                    check_field("course", 64'(seen.course), 64'(due.course));
                    check_field("date_value", 64'(seen.date_value), 64'(due.date_value));
                end
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= reports_due.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the parser testbench. This module only generates the character
// stream, applies back-pressure on the result side and gives the verdict;
// all prediction and comparison happens in the report checker.
module tb;
    import nrmc_pkg::*;

    // How the two checksum characters of a sentence are produced.
    typedef enum int {
        SUM_UPPER,
        SUM_LOWER,
        SUM_WRONG,
        SUM_JUNK
    } t_sum_style;

    // Cycles without any transaction on either side before we give up.
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_CHARS = 650;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata = '0;     // [7:0] byte_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // From bit 0: status, fix_valid, fix_time, latitude, longitude, speed,
    // course, date_value, zero fill.
    logic [TDATA_W-1:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   chars_sent = 0;
    int   sentences_closed = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    // When set, neither side inserts idle cycles.
    logic steady = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    nmea_rmc_sentence_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rmc_report_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (s_axis_tvalid),
        .i_char_ready   (s_axis_tready),
        .i_char         (s_axis_tdata),
        .i_report_valid (m_axis_tvalid),
        .i_report_ready (m_axis_tready),
        .i_report       (m_axis_tdata),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // Idle lengths: mostly none or short, with the occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // The receiver stalls at random, except during steady stretches.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
        return (upper ? CH_A_UP : CH_A_LOW) + {4'd0, nib} - 8'd10;
    endfunction

    // Any byte except the sentence opener.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_DOLLAR);
        return c;
    endfunction

    function automatic string digit_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    // A decimal field: usually well formed, with too many fraction digits
    // now and then, sometimes cut short by a stray character, and rarely so
    // long that the parser has to saturate.
    function automatic string number_field(input int int_len);
        string s;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 8) return "";
        if (r < 94) begin
            s = digit_run($urandom_range(1, int_len));
            if (r < 22) return s;
            s = {s, ".", digit_run($urandom_range(0, 7))};
            if (r < 88) return s;
            return {s, ".7x1"};
        end
        return digit_run($urandom_range(11, 20));
    endfunction

    // A one-letter field; only its first character matters to the parser.
    function automatic string letter_field(input logic [7:0] usual, input logic [7:0] other);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return "";
        if (r < 46) return $sformatf("%c", usual);
        if (r < 84) return $sformatf("%c", other);
        if (r < 92) return $sformatf("%c%c", other, usual);
        return $sformatf("%c", 8'($urandom_range(65, 90)));
    endfunction

    // The text between '$' and '*' of one RMC-like sentence.
    function automatic string rmc_body();
        string part[13];
        string s;
        int    r;
        int    keep;
        r = $urandom_range(0, 99);
        if (r < 84) part[0] = "GPRMC";
        else if (r < 89) part[0] = "GPRMCX";
        else if (r < 94) part[0] = "GPGGA";
        else if (r < 97) part[0] = "GPR";
        else part[0] = "gprmc";
        part[1] = number_field(6);
        part[2] = letter_field("A", "V");
        part[3] = number_field(4);
        part[4] = letter_field("N", "S");
        part[5] = number_field(5);
        part[6] = letter_field("E", "W");
        part[7] = number_field(3);
        part[8] = number_field(3);
        r = $urandom_range(0, 99);
        if (r < 8) part[9] = "";
        else if (r < 86) part[9] = digit_run(6);
        else if (r < 93) part[9] = {digit_run(4), ".", digit_run(2)};
        else part[9] = digit_run($urandom_range(7, 14));
        part[10] = number_field(2);
        part[11] = letter_field("E", "W");
        part[12] = letter_field("A", "D");
        // Occasionally drop the tail of the sentence, or pile extra fields on.
        r = $urandom_range(0, 99);
        keep = (r < 12) ? $urandom_range(1, 12) : 13;
        s = part[0];
        for (int i = 1; i < keep; i++) s = {s, ",", part[i]};
        if (r >= 95) begin
            for (int i = 0; i < 8; i++) s = {s, ",", $sformatf("%0d", i)};
        end
        return s;
    endfunction

    // One transaction on the character stream. The valid stays high after
    // acceptance so that back-to-back characters need no second assignment.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_sentence(input string body, input t_sum_style style);
        logic [7:0] sum;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        sum = '0;
        for (int i = 0; i < body.len(); i++) sum = sum ^ body[i];
        send_char(CH_DOLLAR);
        send_text(body);
        send_char(CH_STAR);
        case (style)
            SUM_UPPER: begin
                hi_c = hex_char(sum[7:4], 1'b1);
                lo_c = hex_char(sum[3:0], 1'b1);
            end
            SUM_LOWER: begin
                hi_c = hex_char(sum[7:4], 1'b0);
                lo_c = hex_char(sum[3:0], 1'b0);
            end
            SUM_WRONG: begin
                sum = sum ^ (8'd1 << $urandom_range(0, 7));
                hi_c = hex_char(sum[7:4], 1'b1);
                lo_c = hex_char(sum[3:0], 1'b1);
            end
            default: begin
                hi_c = junk_char();
                lo_c = junk_char();
            end
        endcase
        send_char(hi_c);
        send_char(lo_c);
        sentences_closed++;
    endtask

    // Drop the valid and wait until every pending result has been taken.
    // The first edge lets the checker count the last accepted character.
    task automatic hold_until_caught_up();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int         first_random;
        int         r;
        int         cut;
        string      body;
        t_sum_style style;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Bytes outside a sentence are ignored, including
        // ones with every bit low or high.
        send_char(8'hFF);
        send_char(8'h00);
        send_text("\r\n");
        // Every field at the top of its range, with fraction digits to drop,
        // in the southern and western hemispheres.
        send_sentence({"GPRMC,235960.999999,A,9000.000009,S,18000.000001,W,",
                       "9999999999.999999,360.00000,311299"}, SUM_UPPER);
        // Everything at zero.
        send_sentence("GPRMC,000000.00000,V,0000.00000,N,00000.00000,E,0,0,000000", SUM_LOWER);
        // Values far past their limits, some long enough to pin the accumulator.
        send_sentence("GPRMC,999999999999999999999,V,9999.9,N,99999,E,,999,999999,,,A",
                      SUM_LOWER);
        // Number syntax: a second point or a stray letter ends the number,
        // a leading point, a trailing point, and a date with a point in it.
        send_sentence("GPRMC,12.3.4,Ax,12a34,Sx,1.2.3,Wq,.5,7.,0105.25", SUM_UPPER);
        // No fields at all, a short id, a foreign id, and extra id characters.
        send_sentence("GPRMC", SUM_UPPER);
        send_sentence("GPR", SUM_UPPER);
        send_sentence("GPGGA,1", SUM_UPPER);
        send_sentence("GPRMCX,1,A", SUM_LOWER);
        // A bad checksum wins over a bad id.
        send_sentence("GPGGA,1,2", SUM_WRONG);
        // Non-hex checksum characters.
        send_sentence("GPRMC,1", SUM_JUNK);
        // More fields than the field counter can tell apart.
        send_sentence("GPRMC,1,A,2,N,3,E,4,5,6,7,8,9,10,11,12,13,14,15,16,17", SUM_LOWER);
        // A new dollar restarts the sentence, in the body and in the checksum.
        send_text("$GPRMC,12");
        send_sentence("GPRMC,1,A", SUM_UPPER);
        send_text("$GPRMC*4");
        send_sentence("GPRMC,2,A", SUM_UPPER);
        send_text("$GPRMC*");
        send_sentence("GPRMC,3,A", SUM_UPPER);
        hold_until_caught_up();

        // Random part: mostly complete sentences with random content, with
        // noise between them and the odd fragment cut off by a new dollar.
        first_random = chars_sent;
        while (chars_sent - first_random < RANDOM_CHARS) begin
            steady <= ($urandom_range(0, 99) < 20);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_text("\r\n");
            end else if (r < 50) begin
                repeat ($urandom_range(1, 6)) send_char(junk_char());
            end
            if ($urandom_range(0, 99) < 10) begin
                body = rmc_body();
                cut = $urandom_range(0, body.len());
                send_char(CH_DOLLAR);
                if (cut > 0) send_text(body.substr(0, cut - 1));
                r = $urandom_range(0, 99);
                if (r >= 33) send_char(CH_STAR);
                if (r >= 66) send_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
            end
            r = $urandom_range(0, 99);
            if (r < 70) style = SUM_UPPER;
            else if (r < 85) style = SUM_LOWER;
            else if (r < 95) style = SUM_WRONG;
            else style = SUM_JUNK;
            send_sentence(rmc_body(), style);
            if (sentences_closed % 12 == 0) hold_until_caught_up();
        end

        hold_until_caught_up();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
